>>> hdl/multi_channel_deadline_timer_assert.svh
// assertion macros for the deadline timer checker
`ifndef MULTI_CHANNEL_DEADLINE_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_DEADLINE_TIMER_ASSERT_SVH

// consequent checked in the same cycle
`define MCDT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define MCDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mcdt_pkg.sv
// shared types and constants of the deadline timer bank
package mcdt_pkg;

  localparam int OP_W    = 3;
  localparam int INDEX_W = 3;
  localparam int TIME_W  = 32;
  localparam int MASK_W  = 8;
  // wide enough for the slot numbers and the index field of up to 63 timers
  localparam int SLOT_CMP_W = 6;

  localparam logic [TIME_W-1:0] INACTIVE_DEADLINE = '1;

  localparam logic [OP_W-1:0] OP_CHECK        = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_PERIOD   = 3'd1;
  localparam logic [OP_W-1:0] OP_START_ONCE   = 3'd2;
  localparam logic [OP_W-1:0] OP_START_REPEAT = 3'd3;
  localparam logic [OP_W-1:0] OP_DISABLE      = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

>>> hdl/mcdt_in_if.sv
// request channel: operation, timer index, period and current time
interface mcdt_in_if;
  logic                            valid;
  logic                            ready;
  logic [mcdt_pkg::OP_W-1:0]       operation;
  logic [mcdt_pkg::INDEX_W-1:0]    timer_index;
  logic [mcdt_pkg::TIME_W-1:0]     period_ms;
  logic [mcdt_pkg::TIME_W-1:0]     now_ms;

  modport source (output valid, operation, timer_index, period_ms, now_ms, input ready);
  modport sink (input valid, operation, timer_index, period_ms, now_ms, output ready);
endinterface

>>> hdl/mcdt_out_if.sv
// result channel: fired mask, nearest deadline, addressed timer state
interface mcdt_out_if;
  logic                          valid;
  logic                          ready;
  logic [mcdt_pkg::MASK_W-1:0]   fired_mask;
  logic [mcdt_pkg::TIME_W-1:0]   nearest_deadline;
  logic                          indexed_running;

  modport source (output valid, fired_mask, nearest_deadline, indexed_running, input ready);
  modport sink (input valid, fired_mask, nearest_deadline, indexed_running, output ready);
endinterface

>>> hdl/multi_channel_deadline_timer.sv
// top level of the virtual millisecond timer bank
//
//   channel  dir  payload                                          transfer
//   in_ch    in   operation, timer_index, period_ms, now_ms        valid && ready
//   out_ch   out  fired_mask, nearest_deadline, indexed_running    valid && ready
//
// each request is captured, then every timer entry passes in turn
// through the single read-modify-write unit, then the result loads the output register
// reset clears all tables directly; no clearing pass
// in_ch.ready is high only while no request is in work
// a finished result waits in the finish step while the output register is full
// the next request is taken while a result waits in the output register
module multi_channel_deadline_timer #(
  parameter int NUM_TIMERS = 8
) (
  input logic             clk,
  input logic             rst_n,
  mcdt_in_if.sink         in_ch,
  mcdt_out_if.source      out_ch
);

  mcdt_pkg::dp_cmd_t    cmd;
  mcdt_pkg::dp_status_t status;

  mcdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  mcdt_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_operation         (in_ch.operation),
    .in_timer_index       (in_ch.timer_index),
    .in_period_ms         (in_ch.period_ms),
    .in_now_ms            (in_ch.now_ms),
    .out_fired_mask       (out_ch.fired_mask),
    .out_nearest_deadline (out_ch.nearest_deadline),
    .out_indexed_running  (out_ch.indexed_running)
  );

endmodule

>>> hdl/mcdt_ctrl.sv
// sequencer: accept, walk the timer table, hand the result to the output register
module mcdt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mcdt_pkg::dp_cmd_t    cmd,
  input  mcdt_pkg::dp_status_t status
);

  mcdt_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign in_ready  = (state_r == mcdt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      mcdt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mcdt_pkg::ST_SCAN;
        end
      end
      mcdt_pkg::ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_nxt = mcdt_pkg::ST_FINISH;
        end
      end
      mcdt_pkg::ST_FINISH: begin
        if (slot_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mcdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mcdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcdt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/mcdt_dp.sv
// timer tables, per-entry update unit, scan accumulators and result register
module mcdt_dp #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mcdt_pkg::dp_cmd_t              cmd,
  output mcdt_pkg::dp_status_t           status,
  input  logic [mcdt_pkg::OP_W-1:0]      in_operation,
  input  logic [mcdt_pkg::INDEX_W-1:0]   in_timer_index,
  input  logic [mcdt_pkg::TIME_W-1:0]    in_period_ms,
  input  logic [mcdt_pkg::TIME_W-1:0]    in_now_ms,
  output logic [mcdt_pkg::MASK_W-1:0]    out_fired_mask,
  output logic [mcdt_pkg::TIME_W-1:0]    out_nearest_deadline,
  output logic                           out_indexed_running
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW    = mcdt_pkg::SLOT_CMP_W;
  localparam int TW    = mcdt_pkg::TIME_W;

  logic [TW-1:0]               deadline_r [NUM_TIMERS];
  logic [TW-1:0]               period_r   [NUM_TIMERS];
  logic                        repeat_r   [NUM_TIMERS];

  logic [mcdt_pkg::OP_W-1:0]    op_r;
  logic [mcdt_pkg::INDEX_W-1:0] idx_r;
  logic [TW-1:0]                period_in_r;
  logic [TW-1:0]                now_r;
  logic [IDX_W-1:0]             cnt_r;

  logic [mcdt_pkg::MASK_W-1:0]  fired_acc_r, fired_acc_nxt;
  logic [TW-1:0]                min_acc_r, min_acc_nxt;
  logic                         run_acc_r, run_acc_nxt;

  logic [mcdt_pkg::MASK_W-1:0]  fired_out_r;
  logic [TW-1:0]                nearest_out_r;
  logic                         running_out_r;

  logic [TW-1:0] cur_deadline, cur_period, sum_base, sum;
  logic          cur_repeat;
  logic [CW-1:0] slot_ext;
  logic          idx_valid, hit, fire;
  logic [TW-1:0] deadline_nxt, period_nxt;
  logic          repeat_nxt;

  assign cur_deadline = deadline_r[cnt_r];
  assign cur_period   = period_r[cnt_r];
  assign cur_repeat   = repeat_r[cnt_r];
  assign slot_ext     = CW'(cnt_r);
  assign idx_valid    = CW'(idx_r) < CW'(NUM_TIMERS);
  assign hit          = idx_valid && (slot_ext == CW'(idx_r));
  assign fire         = (op_r == mcdt_pkg::OP_CHECK) &&
                        (cur_deadline != mcdt_pkg::INACTIVE_DEADLINE) &&
                        (cur_deadline <= now_r);
  // shared adder: repeat advance on check, arm time on start
  assign sum_base     = (op_r == mcdt_pkg::OP_CHECK) ? cur_deadline : now_r;
  assign sum          = sum_base + cur_period;
  assign status.last  = (cnt_r == IDX_W'(NUM_TIMERS - 1));

  always_comb begin
    deadline_nxt = cur_deadline;
    period_nxt   = cur_period;
    repeat_nxt   = cur_repeat;
    case (op_r)
      mcdt_pkg::OP_CHECK: begin
        if (fire) begin
          deadline_nxt = cur_repeat ? sum : mcdt_pkg::INACTIVE_DEADLINE;
        end
      end
      mcdt_pkg::OP_SET_PERIOD: begin
        if (hit) begin
          period_nxt = period_in_r;
        end
      end
      mcdt_pkg::OP_START_ONCE: begin
        if (hit) begin
          repeat_nxt   = 1'b0;
          deadline_nxt = sum;
        end
      end
      mcdt_pkg::OP_START_REPEAT: begin
        if (hit) begin
          repeat_nxt   = 1'b1;
          deadline_nxt = sum;
        end
      end
      mcdt_pkg::OP_DISABLE: begin
        if (hit) begin
          repeat_nxt   = 1'b0;
          deadline_nxt = mcdt_pkg::INACTIVE_DEADLINE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    fired_acc_nxt = fired_acc_r;
    if (fire && (slot_ext < CW'(mcdt_pkg::MASK_W))) begin
      fired_acc_nxt[slot_ext[2:0]] = 1'b1;
    end
    min_acc_nxt = (deadline_nxt < min_acc_r) ? deadline_nxt : min_acc_r;
    run_acc_nxt = hit ? (deadline_nxt != mcdt_pkg::INACTIVE_DEADLINE) : run_acc_r;
  end

  // timer tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        deadline_r[i] <= mcdt_pkg::INACTIVE_DEADLINE;
        period_r[i]   <= '0;
        repeat_r[i]   <= 1'b0;
      end
    end else if (cmd.step) begin
      deadline_r[cnt_r] <= deadline_nxt;
      period_r[cnt_r]   <= period_nxt;
      repeat_r[cnt_r]   <= repeat_nxt;
    end
  end

  // request capture, scan counter and accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_operation;
      idx_r       <= in_timer_index;
      period_in_r <= in_period_ms;
      now_r       <= in_now_ms;
      cnt_r       <= '0;
      fired_acc_r <= '0;
      min_acc_r   <= mcdt_pkg::INACTIVE_DEADLINE;
      run_acc_r   <= 1'b0;
    end else if (cmd.step) begin
      cnt_r       <= status.last ? cnt_r : cnt_r + IDX_W'(1);
      fired_acc_r <= fired_acc_nxt;
      min_acc_r   <= min_acc_nxt;
      run_acc_r   <= run_acc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      fired_out_r   <= fired_acc_r;
      nearest_out_r <= min_acc_r;
      running_out_r <= run_acc_r;
    end
  end

  assign out_fired_mask       = fired_out_r;
  assign out_nearest_deadline = nearest_out_r;
  assign out_indexed_running  = running_out_r;

endmodule

>>> hdl/mcdt_checker.sv
// port-level checker for the timer bank, bound to the top level
`include "multi_channel_deadline_timer_assert.svh"

module mcdt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mcdt_pkg::MASK_W-1:0]       fired_mask,
  input logic [mcdt_pkg::TIME_W-1:0]       nearest_deadline,
  input logic                              indexed_running
);

  // a stalled result stays offered
  `MCDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `MCDT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(fired_mask) && $stable(nearest_deadline) && $stable(indexed_running), "result changed while stalled")

  // one request in work at a time
  `MCDT_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "request taken during a scan")

  // a running addressed timer implies a pending deadline
  `MCDT_ASSERT_SAME(a_running_pending, out_valid && indexed_running, nearest_deadline != mcdt_pkg::INACTIVE_DEADLINE, "running timer but no pending deadline")

endmodule

bind multi_channel_deadline_timer mcdt_checker u_mcdt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .fired_mask       (out_ch.fired_mask),
  .nearest_deadline (out_ch.nearest_deadline),
  .indexed_running  (out_ch.indexed_running)
);
